// ===== hw/rtl/ftns_pkg.sv =====
// Shared constants, request and status codes, and the control/status structs
// of the feature table search core. No dependencies.
package ftns_pkg;

  localparam int TABLE_ROWS     = 512;
  localparam int MAX_VECTOR_LEN = 512;

  localparam int ROW_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int IDX_W = (MAX_VECTOR_LEN > 1) ? $clog2(MAX_VECTOR_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_VECTOR_LEN + 1);
  localparam int ADDR_W = ROW_W + IDX_W;

  localparam int TYPE_W    = 3;
  localparam int REQ_ROW_W = 10;
  localparam int ELEM_W    = 16;
  localparam int VLEN_W    = 10;
  localparam int STATUS_W  = 3;
  localparam int RES_ROW_W = 9;
  localparam int SCORE_W   = 41;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = PROD_W + IDX_W;
  localparam int ACC_W     = (SUM_W > SCORE_W) ? SUM_W : SCORE_W;

  localparam logic [VLEN_W-1:0] VLEN_RESET = 10'd512;

  localparam logic [TYPE_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_REG    = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_UPDATE = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_SEARCH = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SIZE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DEL_ROW  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DEL_IDLE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UPD_IDLE = 3'd5;

  localparam logic signed [ACC_W-1:0] ACC_SMAX =
    {{(ACC_W-SCORE_W+1){1'b0}}, {(SCORE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_SMIN =
    {{(ACC_W-SCORE_W+1){1'b1}}, {(SCORE_W-1){1'b0}}};

  typedef struct packed {
    logic                accept;
    logic                begin_req;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                tgt_req;
    logic                tgt_scan;
    logic                set_used;
    logic                clr_used;
    logic                scan_clr;
    logic                scan_inc;
    logic                j_clr;
    logic                copy_rd;
    logic                mac_rd;
    logic                acc_clr;
    logic                cmp;
    logic                finish;
  } ftns_cmd_t;

  typedef struct packed {
    logic              len_ok;
    logic              row_ok;
    logic              used_req;
    logic              used_scan;
    logic              scan_last;
    logic              j_last;
    logic [TYPE_W-1:0] req_type;
  } ftns_sts_t;

  function automatic logic signed [SCORE_W-1:0] sat_score(
    input logic signed [ACC_W-1:0] v);
    logic signed [SCORE_W-1:0] r;
    if (v > ACC_SMAX) r = ACC_SMAX[SCORE_W-1:0];
    else if (v < ACC_SMIN) r = ACC_SMIN[SCORE_W-1:0];
    else r = v[SCORE_W-1:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/ftns_ctrl.sv =====
// Sequencer of the feature table search core: request decode, idle row scan,
// row copy and search walk. Depends on ftns_pkg.
module ftns_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_last,
  input  ftns_pkg::ftns_sts_t sts,
  output ftns_pkg::ftns_cmd_t cmd,
  output logic               busy,
  output logic               out_valid
);
  import ftns_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_FIND   = 4'd2;
  localparam logic [3:0] S_COPY   = 4'd3;
  localparam logic [3:0] S_CFIN   = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_MAC    = 4'd6;
  localparam logic [3:0] S_DR1    = 4'd7;
  localparam logic [3:0] S_DR2    = 4'd8;
  localparam logic [3:0] S_CMP    = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (in_last) state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.begin_req = 1'b1;
        state_nxt     = S_DONE;
        unique case (sts.req_type)
          REQ_ADD: begin
            if (!sts.len_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_SIZE;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_FIND;
            end
          end
          REQ_DELETE: begin
            if (!sts.row_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_DEL_ROW;
            end else if (!sts.used_req) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_DEL_IDLE;
            end else begin
              cmd.clr_used = 1'b1;
            end
          end
          REQ_REG: begin
            if (!sts.row_ok || !sts.len_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_SIZE;
            end else begin
              cmd.tgt_req = 1'b1;
              cmd.j_clr   = 1'b1;
              state_nxt   = S_COPY;
            end
          end
          REQ_UPDATE: begin
            if (!sts.row_ok || !sts.len_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_SIZE;
            end else if (!sts.used_req) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_UPD_IDLE;
            end else begin
              cmd.tgt_req = 1'b1;
              cmd.j_clr   = 1'b1;
              state_nxt   = S_COPY;
            end
          end
          REQ_SEARCH: begin
            if (!sts.len_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_SIZE;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = S_SCAN;
            end
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_SIZE;
          end
        endcase
      end
      S_FIND: begin
        if (!sts.used_scan) begin
          cmd.tgt_scan = 1'b1;
          cmd.j_clr    = 1'b1;
          state_nxt    = S_COPY;
        end else if (sts.scan_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
          state_nxt      = S_DONE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_COPY: begin
        cmd.copy_rd = 1'b1;
        if (sts.j_last) state_nxt = S_CFIN;
      end
      S_CFIN: begin
        // The last element lands in the table at this edge.
        cmd.set_used = 1'b1;
        state_nxt    = S_DONE;
      end
      S_SCAN: begin
        if (sts.used_scan) begin
          cmd.j_clr   = 1'b1;
          cmd.acc_clr = 1'b1;
          state_nxt   = S_MAC;
        end else if (sts.scan_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_MAC: begin
        cmd.mac_rd = 1'b1;
        if (sts.j_last) state_nxt = S_DR1;
      end
      S_DR1: state_nxt = S_DR2;
      S_DR2: state_nxt = S_CMP;
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/ftns_dp.sv =====
// Datapath of the feature table search core: staging buffer, vector table,
// used flags, multiply-accumulate and best-score tracking. Depends on ftns_pkg.
module ftns_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ftns_pkg::ftns_cmd_t                   cmd,
  output ftns_pkg::ftns_sts_t                   sts,
  input  logic                                  cfg_we,
  input  logic [ftns_pkg::VLEN_W-1:0]           cfg_data,
  input  logic [ftns_pkg::TYPE_W-1:0]           in_req_type,
  input  logic [ftns_pkg::REQ_ROW_W-1:0]        in_row,
  input  logic signed [ftns_pkg::ELEM_W-1:0]    in_element,
  output logic [ftns_pkg::STATUS_W-1:0]         out_status,
  output logic                                  out_found,
  output logic [ftns_pkg::RES_ROW_W-1:0]        out_result_row,
  output logic signed [ftns_pkg::SCORE_W-1:0]   out_score
);
  import ftns_pkg::*;

  logic signed [ELEM_W-1:0] staging_mem [0:(2**IDX_W)-1];
  logic signed [ELEM_W-1:0] vector_mem  [0:(2**ADDR_W)-1];
  logic [TABLE_ROWS-1:0]    used_r;

  logic [VLEN_W-1:0]    vlen_r;
  logic [CNT_W-1:0]     count_r;
  logic                 ovf_r;
  logic [TYPE_W-1:0]    type_r;
  logic [REQ_ROW_W-1:0] req_row_r;
  logic [ROW_W-1:0]     tgt_r;
  logic [ROW_W-1:0]     scan_r;
  logic [IDX_W-1:0]     j_r;

  logic signed [ELEM_W-1:0] st_rd_r;
  logic signed [ELEM_W-1:0] vs_rd_r;
  logic                     cp_v_r;
  logic [IDX_W-1:0]         cp_j_r;
  logic                     m_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     p_v_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  best_r;
  logic                     found_r;
  logic [ROW_W-1:0]         res_row_r;
  logic [STATUS_W-1:0]      status_r;

  assign sts.len_ok    = !ovf_r && (vlen_r != '0) && (32'(vlen_r) <= MAX_VECTOR_LEN) &&
                         (32'(count_r) == 32'(vlen_r));
  assign sts.row_ok    = (32'(req_row_r) < TABLE_ROWS);
  assign sts.used_req  = used_r[req_row_r[ROW_W-1:0]];
  assign sts.used_scan = used_r[scan_r];
  assign sts.scan_last = (scan_r == ROW_W'(TABLE_ROWS - 1));
  assign sts.j_last    = (32'(j_r) == 32'(vlen_r) - 32'd1);
  assign sts.req_type  = type_r;

  assign out_status     = status_r;
  assign out_found      = found_r;
  assign out_result_row = RES_ROW_W'(res_row_r);
  assign out_score      = sat_score(best_r);

  // Request capture: type and row come from the first item of a request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r    <= VLEN_RESET;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      type_r    <= REQ_ADD;
      req_row_r <= '0;
    end else begin
      if (cfg_we) vlen_r <= cfg_data;
      if (cmd.accept) begin
        if (count_r == '0 && !ovf_r) begin
          type_r    <= in_req_type;
          req_row_r <= in_row;
        end
        if (32'(count_r) < MAX_VECTOR_LEN) count_r <= count_r + 1'b1;
        else ovf_r <= 1'b1;
      end
      if (cmd.finish) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && 32'(count_r) < MAX_VECTOR_LEN)
      staging_mem[count_r[IDX_W-1:0]] <= in_element;
    if (cmd.copy_rd || cmd.mac_rd)
      st_rd_r <= staging_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (cp_v_r) vector_mem[{tgt_r, cp_j_r}] <= st_rd_r;
    if (cmd.mac_rd) vs_rd_r <= vector_mem[{scan_r, j_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      if (cmd.clr_used) used_r[req_row_r[ROW_W-1:0]] <= 1'b0;
      if (cmd.set_used) used_r[tgt_r] <= 1'b1;
    end
  end

  // Walk counters and pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      j_r    <= '0;
      cp_v_r <= 1'b0;
      m_v_r  <= 1'b0;
      p_v_r  <= 1'b0;
    end else begin
      if (cmd.scan_clr) scan_r <= '0;
      else if (cmd.scan_inc) scan_r <= scan_r + 1'b1;
      if (cmd.j_clr) j_r <= '0;
      else if (cmd.copy_rd || cmd.mac_rd) j_r <= j_r + 1'b1;
      cp_v_r <= cmd.copy_rd;
      m_v_r  <= cmd.mac_rd;
      p_v_r  <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    cp_j_r <= j_r;
    prod_r <= st_rd_r * vs_rd_r;
    if (cmd.tgt_req) tgt_r <= req_row_r[ROW_W-1:0];
    else if (cmd.tgt_scan) tgt_r <= scan_r;
    if (cmd.acc_clr) acc_r <= '0;
    else if (p_v_r) acc_r <= acc_r + ACC_W'(prod_r);
  end

  // Result registers; ties go to the later row since rows are walked upward.
  always_ff @(posedge clk) begin
    if (cmd.set_status) status_r <= cmd.status;
    else if (cmd.begin_req) status_r <= ST_OK;
    if (cmd.begin_req) begin
      found_r   <= 1'b0;
      res_row_r <= '0;
      best_r    <= '0;
    end
    if (cmd.tgt_scan) res_row_r <= scan_r;
    if (cmd.cmp && (!found_r || acc_r >= best_r)) begin
      best_r    <= acc_r;
      res_row_r <= scan_r;
      found_r   <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/feature_table_nearest_search_core.sv =====
// Top level of the feature table search core: sequencer plus datapath.
// Depends on ftns_pkg, ftns_ctrl and ftns_dp.
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------------
//  input   | start, busy             | in_req_type, in_row, in_element, in_last
//  result  | out_valid (strobe)      | out_status, out_found, out_result_row, out_score
//  config  | cfg_valid, cfg_ready    | cfg_vector_length
//
// Elements are taken one per cycle while the core is not busy. Delete and error requests
// then pass only the decide and done states. Add scans the used flags one row a cycle,
// then copies vector_length elements one a cycle. Search skips idle rows one a cycle and
// walks used rows through MAC, drain and compare, bounded by the single table read port.
// Reset empties the table at once; the result strobe lasts one cycle and cannot stall.
module feature_table_nearest_search_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [ftns_pkg::TYPE_W-1:0]           in_req_type,
  input  logic [ftns_pkg::REQ_ROW_W-1:0]        in_row,
  input  logic signed [ftns_pkg::ELEM_W-1:0]    in_element,
  input  logic                                  in_last,
  output logic                                  out_valid,
  output logic [ftns_pkg::STATUS_W-1:0]         out_status,
  output logic                                  out_found,
  output logic [ftns_pkg::RES_ROW_W-1:0]        out_result_row,
  output logic signed [ftns_pkg::SCORE_W-1:0]   out_score,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ftns_pkg::VLEN_W-1:0]           cfg_vector_length
);
  import ftns_pkg::*;

  ftns_cmd_t cmd;
  ftns_sts_t sts;

  assign cfg_ready = !busy;

  ftns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_last   (in_last),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ftns_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_vector_length),
    .in_req_type    (in_req_type),
    .in_row         (in_row),
    .in_element     (in_element),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_result_row (out_result_row),
    .out_score      (out_score)
  );

endmodule

// ===== hw/rtl/ftns_chk.sv =====
// Port-level checks of the feature table search core, bound to the top level.
// Depends on ftns_pkg.
module ftns_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                in_last,
  input logic                                out_valid,
  input logic [ftns_pkg::STATUS_W-1:0]       out_status,
  input logic                                out_found,
  input logic [ftns_pkg::RES_ROW_W-1:0]      out_result_row,
  input logic signed [ftns_pkg::SCORE_W-1:0] out_score
);
  import ftns_pkg::*;

  // A result transfer is a single-cycle strobe and the core is free right after.
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last) |=> !out_valid && !busy)
    else $error("result without a last element");

  a_nf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_score == '0))
    else $error("score without a match");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (!out_found && out_result_row == '0))
    else $error("error result carries a match");

endmodule

bind feature_table_nearest_search_core ftns_chk u_ftns_chk (.*);

// ===== bench/feature_table_nearest_search_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for feature_table_nearest_search_core: requests are streamed
// in bursts, a behavioral table model predicts every result. Depends on ftns_pkg.
module feature_table_nearest_search_core_tb;
  import ftns_pkg::*;

  typedef struct {
    logic [TYPE_W-1:0]           rtype;
    logic [REQ_ROW_W-1:0]        row;
    logic signed [ELEM_W-1:0]    elem;
    logic                        last;
  } elem_item_t;

  typedef struct {
    logic [STATUS_W-1:0]         status;
    logic                        found;
    logic [RES_ROW_W-1:0]        row;
    logic signed [SCORE_W-1:0]   score;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [TYPE_W-1:0] in_req_type = '0;
  logic [REQ_ROW_W-1:0] in_row = '0;
  logic signed [ELEM_W-1:0] in_element = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic out_found;
  logic [RES_ROW_W-1:0] out_result_row;
  logic signed [SCORE_W-1:0] out_score;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [VLEN_W-1:0] cfg_vector_length = '0;

  elem_item_t pending_elems[$];
  answer_t    answers_due[$];
  bit         failed = 1'b0;

  // Table mirror.
  shortint   table_mem[TABLE_ROWS][MAX_VECTOR_LEN];
  bit        row_used[TABLE_ROWS];
  shortint   query_buf[MAX_VECTOR_LEN];
  int        elem_cnt;
  int        lat_row;
  int        lat_type;
  bit        too_long;
  int        vlen;

  int burst_left = 0;
  int gap_left = 0;

  feature_table_nearest_search_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_row(in_row), .in_element(in_element),
    .in_last(in_last), .out_valid(out_valid), .out_status(out_status),
    .out_found(out_found), .out_result_row(out_result_row), .out_score(out_score),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_vector_length(cfg_vector_length)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic model_request_elem(input elem_item_t it);
    answer_t a;
    bit len_ok, row_ok;
    int n, free_row;
    longint s, best;
    if (elem_cnt == 0 && !too_long) begin
      lat_type = it.rtype;
      lat_row = it.row;
    end
    if (elem_cnt < MAX_VECTOR_LEN) begin
      query_buf[elem_cnt] = it.elem;
      elem_cnt++;
    end else begin
      too_long = 1'b1;
    end
    if (!it.last) return;
    n = elem_cnt;
    len_ok = !too_long && vlen >= 1 && vlen <= MAX_VECTOR_LEN && n == vlen;
    row_ok = lat_row < TABLE_ROWS;
    elem_cnt = 0;
    too_long = 1'b0;
    a.status = ST_OK;
    a.found = 1'b0;
    a.row = '0;
    best = 0;
    case (lat_type)
      REQ_ADD: begin
        if (!len_ok) a.status = ST_SIZE;
        else begin
          free_row = TABLE_ROWS;
          for (int i = TABLE_ROWS - 1; i >= 0; i--) if (!row_used[i]) free_row = i;
          if (free_row == TABLE_ROWS) a.status = ST_FULL;
          else begin
            for (int k = 0; k < n; k++) table_mem[free_row][k] = query_buf[k];
            row_used[free_row] = 1'b1;
            a.row = free_row;
          end
        end
      end
      REQ_DELETE: begin
        if (!row_ok) a.status = ST_DEL_ROW;
        else if (!row_used[lat_row]) a.status = ST_DEL_IDLE;
        else row_used[lat_row] = 1'b0;
      end
      REQ_REG: begin
        if (!row_ok || !len_ok) a.status = ST_SIZE;
        else begin
          for (int k = 0; k < n; k++) table_mem[lat_row][k] = query_buf[k];
          row_used[lat_row] = 1'b1;
        end
      end
      REQ_UPDATE: begin
        if (!row_ok || !len_ok) a.status = ST_SIZE;
        else if (!row_used[lat_row]) a.status = ST_UPD_IDLE;
        else for (int k = 0; k < n; k++) table_mem[lat_row][k] = query_buf[k];
      end
      REQ_SEARCH: begin
        if (!len_ok) a.status = ST_SIZE;
        else begin
          for (int i = 0; i < TABLE_ROWS; i++) begin
            if (row_used[i]) begin
              s = 0;
              for (int k = 0; k < n; k++)
                s += longint'(table_mem[i][k]) * longint'(query_buf[k]);
              // Ties go to the higher row, so a later equal score wins.
              if (!a.found || s >= best) begin
                best = s;
                a.row = i;
                a.found = 1'b1;
              end
            end
          end
        end
      end
      default: a.status = ST_SIZE;
    endcase
    if (best > 64'sh0FF_FFFF_FFFF) best = 64'sh0FF_FFFF_FFFF;
    if (best < -64'sh100_0000_0000) best = -64'sh100_0000_0000;
    a.score = best[SCORE_W-1:0];
    answers_due.insert(answers_due.size(), a);
  endtask

  // Accepted transfers are modeled here, results checked against the oldest answer.
  always @(posedge clk) begin
    answer_t a;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) vlen = cfg_vector_length;
      if (start && !busy) begin
        model_request_elem(pending_elems[0]);
        pending_elems.pop_front();
      end
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected result status=%0d row=%0d", $time, out_status,
                   out_result_row);
          failed = 1'b1;
        end else begin
          a = answers_due.pop_front();
          if (out_status !== a.status) begin
            $display("%0t: status expected %0d actual %0d", $time, a.status, out_status);
            failed = 1'b1;
          end
          if (out_found !== a.found) begin
            $display("%0t: found expected %0d actual %0d", $time, a.found, out_found);
            failed = 1'b1;
          end
          if (out_result_row !== a.row) begin
            $display("%0t: row expected %0d actual %0d", $time, a.row, out_result_row);
            failed = 1'b1;
          end
          if (out_score !== a.score) begin
            $display("%0t: score expected %0d actual %0d", $time, a.score, out_score);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Sender: bursts of transfers separated by random gaps.
  always @(negedge clk) begin
    if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_elems.size() > 0 && rst_n) begin
      start <= 1'b1;
      in_req_type <= pending_elems[0].rtype;
      in_row <= pending_elems[0].row;
      in_element <= pending_elems[0].elem;
      in_last <= pending_elems[0].last;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  function automatic logic signed [ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // mode 0 random elements, 1 all minimum, 2 all maximum
  task automatic queue_request(input logic [TYPE_W-1:0] t, input int row, input int len,
                               input int mode);
    elem_item_t it;
    for (int k = 0; k < len; k++) begin
      it.rtype = (k == 0) ? t : TYPE_W'($urandom);
      it.row = (k == 0) ? REQ_ROW_W'(row) : REQ_ROW_W'($urandom);
      it.elem = (mode == 1) ? 16'sh8000 : (mode == 2) ? 16'sh7FFF : pick_elem();
      it.last = (k == len - 1);
      pending_elems.insert(pending_elems.size(), it);
    end
  endtask

  task automatic drain();
    wait (pending_elems.size() == 0 && answers_due.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_vlen(input int v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_vector_length <= VLEN_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int v, input int n_elems);
    int sent, len, row, pick;
    logic [TYPE_W-1:0] t;
    write_vlen(v);
    sent = 0;
    while (sent < n_elems) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) t = REQ_ADD;
      else if (pick < 45) t = REQ_REG;
      else if (pick < 60) t = REQ_UPDATE;
      else if (pick < 75) t = REQ_DELETE;
      else if (pick < 95) t = REQ_SEARCH;
      else t = REQ_SEARCH + TYPE_W'($urandom_range(1, 3));
      row = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
      len = v;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, v + 1);
      if (t == REQ_DELETE && $urandom_range(0, 1)) len = $urandom_range(1, 3);
      queue_request(t, row, len, 0);
      sent += len;
    end
  endtask

  initial begin
    elem_cnt = 0;
    lat_row = 0;
    lat_type = 0;
    too_long = 1'b0;
    vlen = VLEN_RESET;
    foreach (row_used[i]) row_used[i] = 1'b0;
    foreach (table_mem[i, k]) table_mem[i][k] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Lengths only shrink from here on, so no row is read past what was written.
    random_phase(23, 350);
    random_phase(4, 150);
    random_phase(2, 100);

    // Lengths outside the legal range reject every length-checked request.
    write_vlen(0);
    queue_request(REQ_SEARCH, 0, 1, 0);
    queue_request(REQ_ADD, 0, 1, 0);
    write_vlen(1000);
    queue_request(REQ_REG, 3, 3, 0);
    queue_request(REQ_DELETE, 3, 1, 0);

    // Length one: fill the table, hit the full case and every status.
    write_vlen(1);
    for (int i = 0; i < TABLE_ROWS; i++) queue_request(REQ_ADD, 0, 1, 0);
    queue_request(REQ_SEARCH, 0, 1, 2);
    queue_request(REQ_DELETE, 600, 1, 0);
    queue_request(REQ_DELETE, 5, 1, 0);
    queue_request(REQ_DELETE, 5, 2, 0);
    queue_request(REQ_UPDATE, 5, 1, 0);
    queue_request(REQ_REG, 5, 1, 1);
    queue_request(REQ_UPDATE, 5, 1, 2);
    queue_request(REQ_REG, 700, 1, 0);
    queue_request(REQ_UPDATE, 1023, 1, 0);
    queue_request(REQ_SEARCH + 3'd2, 0, 1, 0);
    queue_request(REQ_SEARCH, 0, 2, 0);
    queue_request(REQ_SEARCH, 0, 1, 1);

    drain();
    repeat (50) @(posedge clk);
    if (!failed) $display("feature_table_nearest_search_core test passed");
    else $display("feature_table_nearest_search_core test failed");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("feature_table_nearest_search_core test failed");
    $finish;
  end

endmodule
